@@ rtl/core/spq_pkg.sv @@
// Package with the types and constants shared by the priority queue modules.
package spq_pkg;

  // Queue geometry and field widths.
  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 32;
  localparam int PRIO_W   = 16;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Operation broadcast to every cell of the row.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ENQ,
    OP_DEQ,
    OP_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [PRIO_W-1:0]   prio;
    logic [VALUE_W-1:0]  value;
  } cell_cmd_t;

  // Contents of one slot.
  typedef struct packed {
    logic                used;
    logic [PRIO_W-1:0]   prio;
    logic [VALUE_W-1:0]  value;
  } slot_t;

  // Input request payload.
  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [VALUE_W-1:0]  item_value;
    logic [PRIO_W-1:0]   item_priority;
  } in_item_t;

  // Result payload.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  out_value;
    logic                out_valid;
    logic [COUNT_W-1:0]  entry_count;
    logic [VALUE_W-1:0]  head_value;
    logic [PRIO_W-1:0]   head_priority;
    logic                head_valid;
  } out_item_t;

endpackage

@@ rtl/core/spq_cell.sv @@
// One slot of the sorted row: holds an entry and inserts or shifts it locally.
module spq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic              left_keep,
  input  spq_pkg::slot_t    left_slot,
  input  spq_pkg::slot_t    right_slot,
  output spq_pkg::slot_t    slot,
  output spq_pkg::slot_t    slot_nxt,
  output logic              keep
);
  import spq_pkg::*;

  logic               used_r;
  logic [PRIO_W-1:0]  prio_r;
  logic [VALUE_W-1:0] value_r;

  assign slot = '{used: used_r, prio: prio_r, value: value_r};

  // An entry stays in place on insert when it ranks at or ahead of the new one.
  assign keep = used_r && (prio_r <= cmd.prio);

  // Next contents of the slot.
  always_comb begin
    slot_nxt = slot;
    unique case (cmd.op)
      OP_HOLD: begin
        slot_nxt = slot;
      end
      OP_CLEAR: begin
        slot_nxt.used = 1'b0;
      end
      OP_ENQ: begin
        if (keep) begin
          slot_nxt = slot;
        end else if (left_keep) begin
          slot_nxt = '{used: 1'b1, prio: cmd.prio, value: cmd.value};
        end else begin
          slot_nxt = left_slot;
        end
      end
      OP_DEQ: begin
        slot_nxt = right_slot;
      end
      default: begin
        slot_nxt = slot;
      end
    endcase
  end

  // Occupancy bit is reset; the payload is only read when occupied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= slot_nxt.used;
    end
  end

  always_ff @(posedge clk) begin
    prio_r  <= slot_nxt.prio;
    value_r <= slot_nxt.value;
  end

endmodule

@@ rtl/core/stable_priority_queue_core.sv @@
// Top level of the stable bounded priority queue built from a row of slot cells.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   in_item  (req_type, item_value, item_priority)
//   out_     output     out_valid/out_stall out_item (status, out_value, ..., head_valid)
//
// Every request is applied to all cells of the row in the cycle it is accepted,
// so the queue takes one request per cycle while in_stall is low; the result
// appears in the next cycle. The result sits in an output register; in_stall
// is high only while that register holds a result that the receiver stalls.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
module stable_priority_queue_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_item_t out_item
);
  import spq_pkg::*;

  logic                 accept;
  cell_cmd_t            cmd;
  logic [STATUS_W-1:0]  status;
  logic [COUNT_W-1:0]   count_r;
  logic [COUNT_W-1:0]   count_nxt;
  logic                 out_valid_r;
  out_item_t            out_item_r;
  out_item_t            result;

  slot_t slot_cur [CAPACITY];
  slot_t slot_new [CAPACITY];
  logic  keep_w   [CAPACITY];

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Decode the request into a cell operation; full, empty and unused codes hold.
  always_comb begin
    cmd.prio  = in_item.item_priority;
    cmd.value = in_item.item_value;
    cmd.op    = OP_HOLD;
    status    = ST_OK;
    if (accept) begin
      unique case (in_item.req_type)
        REQ_ENQUEUE: begin
          if (count_r == COUNT_W'(CAPACITY)) begin
            status = ST_FULL;
          end else begin
            cmd.op = OP_ENQ;
          end
        end
        REQ_DEQUEUE: begin
          if (count_r == '0) begin
            status = ST_EMPTY;
          end else begin
            cmd.op = OP_DEQ;
          end
        end
        REQ_CLEAR: begin
          cmd.op = OP_CLEAR;
        end
        default: begin
          cmd.op = OP_HOLD;
        end
      endcase
    end
  end

  // Row of cells; each one sees its left and right neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t left_slot;
    slot_t right_slot;
    logic  left_keep;

    if (i == 0) begin : g_first
      assign left_slot = '0;
      assign left_keep = 1'b1;
    end else begin : g_inner_l
      assign left_slot = slot_cur[i-1];
      assign left_keep = keep_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_slot = '0;
    end else begin : g_inner_r
      assign right_slot = slot_cur[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_keep  (left_keep),
      .left_slot  (left_slot),
      .right_slot (right_slot),
      .slot       (slot_cur[i]),
      .slot_nxt   (slot_new[i]),
      .keep       (keep_w[i])
    );
  end

  // Entry count after the request.
  always_comb begin
    unique case (cmd.op)
      OP_ENQ:   count_nxt = count_r + COUNT_W'(1);
      OP_DEQ:   count_nxt = count_r - COUNT_W'(1);
      OP_CLEAR: count_nxt = '0;
      OP_HOLD:  count_nxt = count_r;
      default:  count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Assemble the result: dequeued value from the current head, head fields after the request.
  always_comb begin
    result.status        = status;
    result.out_valid     = (cmd.op == OP_DEQ);
    result.out_value     = (cmd.op == OP_DEQ) ? slot_cur[0].value : '0;
    result.entry_count   = count_nxt;
    result.head_valid    = slot_new[0].used;
    result.head_value    = slot_new[0].used ? slot_new[0].value : '0;
    result.head_priority = slot_new[0].used ? slot_new[0].prio : '0;
  end

  // Output register: loads on every transfer in, empties on a transfer out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= result;
    end
  end

endmodule

@@ rtl/core/spq_checker.sv @@
// Port-level checker for the priority queue, bound to the top level.
module spq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input spq_pkg::out_item_t out_item
);
  import spq_pkg::*;

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // The input side only stalls while a result is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // The count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.entry_count <= COUNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // The head is reported exactly when the queue holds entries.
  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.head_valid == (out_item.entry_count != '0))
    else $error("head flag disagrees with count");

  // An accepted full-queue enqueue reports full and keeps the capacity count.
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_FULL |->
      out_item.entry_count == COUNT_W'(CAPACITY) && !out_item.out_valid)
    else $error("full status with queue not full");

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

@@ tb/stable_priority_queue_core_tb.sv @@
// Testbench for the priority queue core: a directed table and random requests.
`timescale 1ns / 1ps

module stable_priority_queue_core_tb;
  import spq_pkg::*;

  // The request code that the queue must treat as a no-op.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1400;
  localparam int LONG_HOLD    = 120;
  localparam int NUM_ROWS     = 11;

  // One row of the directed table; rows without a typed result use the predictor.
  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [VALUE_W-1:0] item_value;
    logic [PRIO_W-1:0]  item_priority;
    logic [4:0]         reps;
    logic               typed;
    out_item_t          result;
  } script_row_t;

  localparam script_row_t SCRIPT [NUM_ROWS] = '{
    // A dequeue right after reset finds the queue empty.
    '{REQ_DEQUEUE, 32'h0, 16'h0, 5'd1, 1'b1,
      '{ST_EMPTY, 32'h0, 1'b0, 5'd0, 32'h0, 16'h0, 1'b0}},
    // The unused code changes nothing.
    '{REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 5'd1, 1'b1,
      '{ST_OK, 32'h0, 1'b0, 5'd0, 32'h0, 16'h0, 1'b0}},
    // Largest value at the largest priority number.
    '{REQ_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 5'd1, 1'b1,
      '{ST_OK, 32'h0, 1'b0, 5'd1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1}},
    // Priority zero moves to the head.
    '{REQ_ENQUEUE, 32'h0, 16'h0, 5'd1, 1'b1,
      '{ST_OK, 32'h0, 1'b0, 5'd2, 32'h0, 16'h0, 1'b1}},
    // An equal priority lines up behind the earlier entry.
    '{REQ_ENQUEUE, 32'h5555_5555, 16'h0, 5'd1, 1'b1,
      '{ST_OK, 32'h0, 1'b0, 5'd3, 32'h0, 16'h0, 1'b1}},
    // Drain the three in service order.
    '{REQ_DEQUEUE, 32'hAAAA_AAAA, 16'hAAAA, 5'd1, 1'b1,
      '{ST_OK, 32'h0, 1'b1, 5'd2, 32'h5555_5555, 16'h0, 1'b1}},
    '{REQ_DEQUEUE, 32'h0, 16'h0, 5'd1, 1'b1,
      '{ST_OK, 32'h5555_5555, 1'b1, 5'd1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1}},
    '{REQ_DEQUEUE, 32'h0, 16'h0, 5'd1, 1'b1,
      '{ST_OK, 32'hFFFF_FFFF, 1'b1, 5'd0, 32'h0, 16'h0, 1'b0}},
    // Fill up with four interleaved runs of equal priority.
    '{REQ_ENQUEUE, 32'hC0DE_0000, 16'h8000, 5'd16, 1'b0, '0},
    // One more enqueue is dropped as full.
    '{REQ_ENQUEUE, 32'h1234_5678, 16'h0, 5'd1, 1'b0, '0},
    // Clearing a full queue empties it.
    '{REQ_CLEAR, 32'h0, 16'h0, 5'd1, 1'b1,
      '{ST_OK, 32'h0, 1'b0, 5'd0, 32'h0, 16'h0, 1'b0}}
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // Predictor state: entries in service order, head in slot zero.
  logic [PRIO_W-1:0]  queue_prio  [CAPACITY];
  logic [VALUE_W-1:0] queue_value [CAPACITY];
  int                 queue_fill = 0;

  out_item_t pending_results [$];
  int        mismatches      = 0;
  int        results_seen    = 0;

  stable_priority_queue_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request to the predictor and return the result it should produce.
  function automatic out_item_t predict_result(input in_item_t req);
    out_item_t res;
    int        pos;
    int        i;
    res = '0;
    res.status = ST_OK;
    case (req.req_type)
      REQ_ENQUEUE: begin
        if (queue_fill >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < queue_fill && queue_prio[pos] <= req.item_priority) pos++;
          for (i = queue_fill; i > pos; i--) begin
            queue_prio[i]  = queue_prio[i-1];
            queue_value[i] = queue_value[i-1];
          end
          queue_prio[pos]  = req.item_priority;
          queue_value[pos] = req.item_value;
          queue_fill++;
        end
      end
      REQ_DEQUEUE: begin
        if (queue_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_value = queue_value[0];
          res.out_valid = 1'b1;
          for (i = 0; i + 1 < queue_fill; i++) begin
            queue_prio[i]  = queue_prio[i+1];
            queue_value[i] = queue_value[i+1];
          end
          queue_fill--;
        end
      end
      REQ_CLEAR: begin
        queue_fill = 0;
      end
      default: begin
      end
    endcase
    res.entry_count = COUNT_W'(queue_fill);
    if (queue_fill > 0) begin
      res.head_value    = queue_value[0];
      res.head_priority = queue_prio[0];
      res.head_valid    = 1'b1;
    end
    return res;
  endfunction

  // Random request; enq_pct sets how far the mix leans toward filling the queue.
  function automatic in_item_t random_request(input int enq_pct);
    in_item_t req;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) req.req_type = REQ_CLEAR;
    else if (roll < 4) req.req_type = REQ_UNUSED;
    else if (roll < 4 + enq_pct * 96 / 100) req.req_type = REQ_ENQUEUE;
    else req.req_type = REQ_DEQUEUE;
    req.item_value = $urandom();
    // Mostly a few priorities, so that ties are common.
    roll = $urandom_range(0, 9);
    if (roll == 0) req.item_priority = PRIO_W'($urandom());
    else if (roll == 1) req.item_priority = '1;
    else if (roll == 2) req.item_priority = '0;
    else req.item_priority = PRIO_W'($urandom_range(0, 7));
    return req;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Offer one request until it transfers, then log what it should produce.
  task automatic offer(input in_item_t req, input logic typed, input out_item_t result);
    out_item_t predicted;
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_result(req);
    pending_results.push_back(typed ? result : predicted);
    @(negedge clk);
  endtask

  task automatic idle_sender();
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop offering until every expected result has arrived.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, seen);
      mismatches++;
    end
  endtask

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected nothing, got %h", $time, out_item);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 64'(want.status), 64'(out_item.status));
        compare_field("out_value", 64'(want.out_value), 64'(out_item.out_value));
        compare_field("out_valid", 64'(want.out_valid), 64'(out_item.out_valid));
        compare_field("entry_count", 64'(want.entry_count),
                      64'(out_item.entry_count));
        compare_field("head_value", 64'(want.head_value),
                      64'(out_item.head_value));
        compare_field("head_priority", 64'(want.head_priority),
                      64'(out_item.head_priority));
        compare_field("head_valid", 64'(want.head_valid),
                      64'(out_item.head_valid));
      end
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold that backs up the input.
  initial begin
    int  hold;
    logic long_hold_done;
    long_hold_done = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end else begin
        hold = idle_length();
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(negedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  // Sender: reset, directed table, then random bursts with varying mixes.
  initial begin
    in_item_t req;
    int       r;
    int       k;
    int       n;
    int       enq_pct;
    logic     calm;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    enq_pct  = 50;
    calm     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < NUM_ROWS; r++) begin
      for (k = 0; k < SCRIPT[r].reps; k++) begin
        req.req_type      = SCRIPT[r].req_type;
        req.item_value    = SCRIPT[r].item_value + VALUE_W'(k);
        req.item_priority = SCRIPT[r].item_priority ^ PRIO_W'(k % 4);
        offer(req, SCRIPT[r].typed, SCRIPT[r].result);
        idle_sender();
      end
    end
    hold_until_drained();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 15;
          1: enq_pct = 50;
          2: enq_pct = 70;
          default: enq_pct = 90;
        endcase
        calm = ($urandom_range(0, 4) == 0);
      end
      offer(random_request(enq_pct), 1'b0, '0);
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      else if (n != RANDOM_ITEMS - 1 && !calm) idle_sender();
    end
    hold_until_drained();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue_core.sv
rtl/core/spq_checker.sv
tb/stable_priority_queue_core_tb.sv
